>>> rtl/core/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the camera scaler setup calculator.
// ----------------------------------------------------------------------------
package css_pkg;

  // default size width of the image dimensions
  localparam int SIZE_BITS_DEF = 12;

  // reset values of the source size registers
  localparam int SRC_WIDTH_RST  = 640;
  localparam int SRC_HEIGHT_RST = 480;

  // width of the 1.8 main ratio result
  localparam int RATIO_BITS = 9;

  // largest prescale shift and ratio limit exponent (64 = 1 << 6)
  localparam int MAX_SHIFT   = 5;
  localparam int RATIO_LIMIT = 6;

  // configuration port
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1
  } reg_idx_t;

  // result error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_RATIO  = 2'd1,
    ERR_WINDOW = 2'd2,
    ERR_ZERO   = 2'd3
  } err_t;

  // dma burst lengths in words
  localparam logic [4:0] BURST_4  = 5'd4;
  localparam logic [4:0] BURST_8  = 5'd8;
  localparam logic [4:0] BURST_16 = 5'd16;

  // classified control part of one word
  typedef struct packed {
    err_t       err;
    logic       win_en;
    logic [1:0] up;
    logic [4:0] mb;
    logic [4:0] rb;
    logic [2:0] hs;
    logic [2:0] vs;
  } ctrl_t;

endpackage

>>> rtl/core/css_req_if.sv
// ----------------------------------------------------------------------------
// css_req_if
// Request channel: target size and crop offsets.
// ----------------------------------------------------------------------------
interface css_req_if #(
  parameter int SIZE_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [SIZE_BITS-1:0] target_width;
  logic [SIZE_BITS-1:0] target_height;
  logic [SIZE_BITS-2:0] win_h_offset;
  logic [SIZE_BITS-2:0] win_v_offset;

  modport source (output valid, target_width, target_height, win_h_offset, win_v_offset,
                  input ready);
  modport sink   (input valid, target_width, target_height, win_h_offset, win_v_offset,
                  output ready);
endinterface

>>> rtl/core/css_res_if.sv
// ----------------------------------------------------------------------------
// css_res_if
// Result channel: scaler setup values.
// ----------------------------------------------------------------------------
interface css_res_if #(
  parameter int SIZE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             error_code;
  logic                   window_enable;
  logic [1:0]             scale_up_flags;
  logic [4:0]             main_burst;
  logic [4:0]             remained_burst;
  logic [2:0]             pre_h_shift;
  logic [2:0]             pre_v_shift;
  logic [SIZE_BITS-1:0]   pre_dst_width;
  logic [SIZE_BITS-1:0]   pre_dst_height;
  logic [8:0]             main_h_ratio;
  logic [8:0]             main_v_ratio;
  logic [2*SIZE_BITS-1:0] target_area;

  modport source (output valid, error_code, window_enable, scale_up_flags, main_burst,
                  remained_burst, pre_h_shift, pre_v_shift, pre_dst_width, pre_dst_height,
                  main_h_ratio, main_v_ratio, target_area, input ready);
  modport sink   (input valid, error_code, window_enable, scale_up_flags, main_burst,
                  remained_burst, pre_h_shift, pre_v_shift, pre_dst_width, pre_dst_height,
                  main_h_ratio, main_v_ratio, target_area, output ready);
endinterface

>>> rtl/core/css_front.sv
// ----------------------------------------------------------------------------
// css_front
// Source size registers and request classification: errors, crop, bursts,
// prescale shifts and divisors.
// ----------------------------------------------------------------------------
module css_front #(
  parameter int SIZE_BITS = css_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [css_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [SIZE_BITS-1:0]              cfg_data,
  input  logic [SIZE_BITS-1:0]              tw_in,
  input  logic [SIZE_BITS-1:0]              th_in,
  input  logic [SIZE_BITS-2:0]              ho_in,
  input  logic [SIZE_BITS-2:0]              vo_in,
  output css_pkg::ctrl_t                    ctrl,
  output logic [SIZE_BITS-1:0]              cw,
  output logic [SIZE_BITS-1:0]              ch,
  output logic [SIZE_BITS+css_pkg::MAX_SHIFT-1:0] dh,
  output logic [SIZE_BITS+css_pkg::MAX_SHIFT-1:0] dv,
  output logic [SIZE_BITS-1:0]              pdw,
  output logic [SIZE_BITS-1:0]              pdh,
  output logic [SIZE_BITS-1:0]              tw,
  output logic [SIZE_BITS-1:0]              th
);
  import css_pkg::*;

  localparam int DB = SIZE_BITS + MAX_SHIFT;
  localparam int LB = SIZE_BITS + RATIO_LIMIT;

  logic [SIZE_BITS-1:0] src_w;
  logic [SIZE_BITS-1:0] src_h;
  logic [SIZE_BITS-1:0] two_ho, two_vo, cw_raw, ch_raw;
  logic [2:0]           hs, vs;
  logic                 err_win, err_zero, err_rat;
  logic [3:0]           m16;
  logic [1:0]           w3;

  // source size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= SIZE_BITS'(SRC_WIDTH_RST);
      src_h <= SIZE_BITS'(SRC_HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w <= cfg_data;
        REG_SRC_HEIGHT: src_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // crop and error checks
  always_comb begin
    two_ho   = {ho_in, 1'b0};
    two_vo   = {vo_in, 1'b0};
    cw_raw   = src_w - two_ho;
    ch_raw   = src_h - two_vo;
    err_win  = (two_ho >= src_w) || (two_vo >= src_h);
    err_zero = (tw_in == '0) || (th_in == '0);
    err_rat  = (LB'(cw_raw) >= {tw_in, RATIO_LIMIT'(0)}) ||
               (LB'(ch_raw) >= {th_in, RATIO_LIMIT'(0)});
  end

  // prescale shift: largest k with crop >= target << k
  always_comb begin
    hs = '0;
    vs = '0;
    for (int k = 1; k <= MAX_SHIFT; k++) begin
      if (DB'(cw_raw) >= (DB'(tw_in) << k)) hs = 3'(k);
      if (DB'(ch_raw) >= (DB'(th_in) << k)) vs = 3'(k);
    end
  end

  // burst lengths from the line length in words
  always_comb begin
    m16 = tw_in[4:1];
    w3  = tw_in[2:1];
    ctrl = '0;
    case (m16)
      4'd0:    begin ctrl.mb = BURST_16; ctrl.rb = BURST_16; end
      4'd4:    begin ctrl.mb = BURST_16; ctrl.rb = BURST_4;  end
      4'd8:    begin ctrl.mb = BURST_16; ctrl.rb = BURST_8;  end
      4'd12:   begin ctrl.mb = BURST_8;  ctrl.rb = BURST_4;  end
      default: begin
        ctrl.mb = BURST_4;
        ctrl.rb = (w3 != 2'd0) ? {3'd0, w3} : BURST_4;
      end
    endcase
    ctrl.win_en = (ho_in != '0) || (vo_in != '0);
    ctrl.up     = {cw_raw < tw_in, ch_raw < th_in};
    ctrl.hs     = hs;
    ctrl.vs     = vs;
    ctrl.err    = ERR_NONE;
    cw  = cw_raw;
    ch  = ch_raw;
    dh  = DB'(tw_in) << hs;
    dv  = DB'(th_in) << vs;
    pdw = cw_raw >> hs;
    pdh = ch_raw >> vs;
    tw  = tw_in;
    th  = th_in;
    // any error zeroes the word
    if (err_win || err_zero || err_rat) begin
      ctrl = '0;
      cw = '0; ch = '0; dh = '0; dv = '0;
      pdw = '0; pdh = '0; tw = '0; th = '0;
      if (err_win)       ctrl.err = ERR_WINDOW;
      else if (err_zero) ctrl.err = ERR_ZERO;
      else               ctrl.err = ERR_RATIO;
    end
  end

endmodule

>>> rtl/core/css_queue.sv
// ----------------------------------------------------------------------------
// css_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module css_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PB-1:0]    wptr, rptr;
  logic [PB:0]      count;

  assign full  = (count == (PB+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full)
        wptr <= (wptr == PB'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop && !empty)
        rptr <= (rptr == PB'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (PB+1)'(push && !full) - (PB+1)'(pop && !empty);
    end
  end

endmodule

>>> rtl/core/css_back.sv
// ----------------------------------------------------------------------------
// css_back
// Area multiply and two pipelined restoring dividers for the main ratios,
// one quotient bit per stage, with the result word taken from the last stage.
// ----------------------------------------------------------------------------
module css_back #(
  parameter int SIZE_BITS = css_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  css_pkg::ctrl_t                    ctrl_in,
  input  logic [SIZE_BITS-1:0]              cw,
  input  logic [SIZE_BITS-1:0]              ch,
  input  logic [SIZE_BITS+css_pkg::MAX_SHIFT-1:0] dh,
  input  logic [SIZE_BITS+css_pkg::MAX_SHIFT-1:0] dv,
  input  logic [SIZE_BITS-1:0]              pdw,
  input  logic [SIZE_BITS-1:0]              pdh,
  input  logic [SIZE_BITS-1:0]              tw,
  input  logic [SIZE_BITS-1:0]              th,
  css_res_if.source                         res
);
  import css_pkg::*;

  localparam int DB = SIZE_BITS + MAX_SHIFT;
  localparam int RB = DB + 1;
  localparam int NS = RATIO_BITS;
  localparam int AB = 2 * SIZE_BITS;

  logic                  v    [NS+1];
  ctrl_t                 ctl  [NS+1];
  logic [SIZE_BITS-1:0]  pw   [NS+1];
  logic [SIZE_BITS-1:0]  ph   [NS+1];
  logic [AB-1:0]         area [NS+1];
  logic [DB-1:0]         dhs  [NS+1];
  logic [DB-1:0]         dvs  [NS+1];
  logic [RB-1:0]         rh   [NS+1];
  logic [RB-1:0]         rv   [NS+1];
  logic [NS-1:0]         qh   [NS+1];
  logic [NS-1:0]         qv   [NS+1];
  logic                  adv;

  // whole pipeline moves unless the finished word is stalled
  assign adv   = !v[NS] || res.ready;
  assign q_pop = adv && !q_empty;

  // load stage: area product and divider setup
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= !q_empty;
    end
    if (adv) begin
      ctl[0]  <= ctrl_in;
      pw[0]   <= pdw;
      ph[0]   <= pdh;
      area[0] <= AB'(tw) * AB'(th);
      dhs[0]  <= dh;
      dvs[0]  <= dv;
      rh[0]   <= RB'(cw);
      rv[0]   <= RB'(ch);
      qh[0]   <= '0;
      qv[0]   <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= NS; s++) begin : g_div
    logic          geh, gev;
    logic [RB-1:0] nh, nv;

    always_comb begin
      geh = rh[s-1] >= RB'(dhs[s-1]);
      gev = rv[s-1] >= RB'(dvs[s-1]);
      nh  = geh ? rh[s-1] - RB'(dhs[s-1]) : rh[s-1];
      nv  = gev ? rv[s-1] - RB'(dvs[s-1]) : rv[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv) begin
        v[s] <= v[s-1];
      end
      if (adv) begin
        ctl[s]  <= ctl[s-1];
        pw[s]   <= pw[s-1];
        ph[s]   <= ph[s-1];
        area[s] <= area[s-1];
        dhs[s]  <= dhs[s-1];
        dvs[s]  <= dvs[s-1];
        rh[s]   <= {nh[RB-2:0], 1'b0};
        rv[s]   <= {nv[RB-2:0], 1'b0};
        qh[s]   <= {qh[s-1][NS-2:0], geh};
        qv[s]   <= {qv[s-1][NS-2:0], gev};
      end
    end
  end

  // result word from the last stage
  always_comb begin
    res.valid          = v[NS];
    res.error_code     = ctl[NS].err;
    res.window_enable  = ctl[NS].win_en;
    res.scale_up_flags = ctl[NS].up;
    res.main_burst     = ctl[NS].mb;
    res.remained_burst = ctl[NS].rb;
    res.pre_h_shift    = ctl[NS].hs;
    res.pre_v_shift    = ctl[NS].vs;
    res.pre_dst_width  = pw[NS];
    res.pre_dst_height = ph[NS];
    res.main_h_ratio   = (ctl[NS].err == ERR_NONE) ? qh[NS] : '0;
    res.main_v_ratio   = (ctl[NS].err == ERR_NONE) ? qv[NS] : '0;
    res.target_area    = area[NS];
  end

endmodule

>>> rtl/core/camera_scaler_setup_calc_top.sv
// ----------------------------------------------------------------------------
// camera_scaler_setup_calc_top
// Camera preview scaler setup calculator.
// ----------------------------------------------------------------------------
// One request word (target size, crop offsets) gives one result word against
// the source size registers. A word is taken every cycle while the four-entry
// queue has room. The front classifies the word combinationally as it enters
// the queue. After that, the word passes in turn through the queue, the load
// stage and the nine stages of the two ratio dividers, which produce one
// quotient bit each. Source size registers are written through
// cfg_we/cfg_index/cfg_data and take effect for the next word.
module camera_scaler_setup_calc_top #(
  parameter int SIZE_BITS = css_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [css_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [SIZE_BITS-1:0]              cfg_data,
  css_req_if.sink                           req,
  css_res_if.source                         res
);
  import css_pkg::*;

  localparam int DB    = SIZE_BITS + MAX_SHIFT;
  localparam int CB    = $bits(ctrl_t);
  localparam int QW    = CB + 6 * SIZE_BITS + 2 * DB;
  localparam int QDEPTH = 4;

  ctrl_t                f_ctrl, b_ctrl;
  logic [SIZE_BITS-1:0] f_cw, f_ch, f_pdw, f_pdh, f_tw, f_th;
  logic [SIZE_BITS-1:0] b_cw, b_ch, b_pdw, b_pdh, b_tw, b_th;
  logic [DB-1:0]        f_dh, f_dv, b_dh, b_dv;
  logic [QW-1:0]        q_wdata, q_rdata;
  logic                 q_full, q_empty, q_pop;

  // front: classify request word
  css_front #(.SIZE_BITS(SIZE_BITS)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .tw_in(req.target_width), .th_in(req.target_height),
    .ho_in(req.win_h_offset), .vo_in(req.win_v_offset),
    .ctrl(f_ctrl), .cw(f_cw), .ch(f_ch), .dh(f_dh), .dv(f_dv),
    .pdw(f_pdw), .pdh(f_pdh), .tw(f_tw), .th(f_th)
  );

  assign req.ready = !q_full;
  assign q_wdata   = {f_ctrl, f_cw, f_ch, f_dh, f_dv, f_pdw, f_pdh, f_tw, f_th};
  assign {b_ctrl, b_cw, b_ch, b_dh, b_dv, b_pdw, b_pdh, b_tw, b_th} = q_rdata;

  // queue between front and back
  css_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(req.valid), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  // back: area and ratio pipeline
  css_back #(.SIZE_BITS(SIZE_BITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop),
    .ctrl_in(b_ctrl), .cw(b_cw), .ch(b_ch), .dh(b_dh), .dv(b_dv),
    .pdw(b_pdw), .pdh(b_pdh), .tw(b_tw), .th(b_th), .res(res)
  );

endmodule

>>> rtl/core/css_checker.sv
// ----------------------------------------------------------------------------
// css_checker
// Port-level assertions on the scaler setup calculator.
// ----------------------------------------------------------------------------
module css_checker #(
  parameter int SIZE_BITS = css_pkg::SIZE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             error_code,
  input logic [4:0]             main_burst,
  input logic [2:0]             pre_h_shift,
  input logic [8:0]             main_h_ratio,
  input logic [2*SIZE_BITS-1:0] target_area
);
  import css_pkg::*;

  // no result word right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled word is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(main_h_ratio) && $stable(error_code))
    else $error("stalled result changed");

  // error word carries zero values
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |->
      main_burst == '0 && main_h_ratio == '0 && target_area == '0)
    else $error("error word not zeroed");

  // good word has a legal burst and shift and a nonzero area
  a_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_NONE |->
      (main_burst == BURST_4 || main_burst == BURST_8 || main_burst == BURST_16) &&
      pre_h_shift <= 3'(MAX_SHIFT) && target_area != '0)
    else $error("bad burst or shift in good word");

endmodule

bind camera_scaler_setup_calc_top css_checker #(.SIZE_BITS(SIZE_BITS)) u_css_checker (
  .clk(clk), .rst(rst), .out_valid(res.valid), .out_ready(res.ready),
  .error_code(res.error_code), .main_burst(res.main_burst),
  .pre_h_shift(res.pre_h_shift), .main_h_ratio(res.main_h_ratio),
  .target_area(res.target_area)
);
